FILE: hdl/scf_pkg.sv
// Shared constants and types for the strip cluster finder.
// Holds register codes, fixed field widths and the configuration struct.
// No dependencies.
package scf_pkg;

    // Default geometry of the strip and ADC words.
    localparam int SCF_ID_BITS   = 12;
    localparam int SCF_ADC_BITS  = 12;
    localparam int SCF_FRAC_BITS = 8;

    // Fixed widths of the running sums.
    localparam int SUM_W  = 24;
    localparam int WSUM_W = 40;
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [WSUM_W-1:0] WSUM_MAX = {WSUM_W{1'b1}};

    // Configuration register widths.
    localparam int GAP_W  = 12;
    localparam int MINW_W = 13;
    localparam int SEED_W = 12;
    localparam int MINS_W = 24;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    // Depth of the queue between the cluster builder and the divider.
    localparam int Q_DEPTH = 4;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VALLEY_GAP      = 8'd0,
        CFG_MIN_WIDTH       = 8'd1,
        CFG_SEED_THRESHOLD  = 8'd2,
        CFG_MIN_CLUSTER_SUM = 8'd3
    } t_cfg_idx;

    // Current configuration as seen by the cluster builder.
    typedef struct packed {
        logic [GAP_W-1:0]  valley_gap;
        logic [MINW_W-1:0] min_width;
        logic [SEED_W-1:0] seed_threshold;
        logic [MINS_W-1:0] min_cluster_sum;
    } t_cfg;

endpackage

FILE: hdl/scf_fifo.sv
// Small first-in first-out queue of cluster records.
// Generic width and depth; no package dependencies.
module scf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage takes no reset.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: hdl/scf_front.sv
// Cluster builder: accepts strip words, tracks the open cluster, applies the
// emission cuts and pushes cluster records toward the queue. Uses scf_pkg.
module scf_front #(
    parameter int STRIP_ID_BITS = scf_pkg::SCF_ID_BITS,
    parameter int ADC_BITS      = scf_pkg::SCF_ADC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  scf_pkg::t_cfg             i_cfg,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [STRIP_ID_BITS-1:0]  i_strip_id,
    input  logic [ADC_BITS-1:0]       i_amplitude,
    input  logic                      i_list_end,
    output logic                      o_push,
    input  logic                      i_full,
    output logic [scf_pkg::WSUM_W-1:0] o_wsum,
    output logic [scf_pkg::SUM_W-1:0]  o_sum,
    output logic [ADC_BITS-1:0]       o_peak,
    output logic [STRIP_ID_BITS:0]    o_span,
    output logic                      o_final
);
    import scf_pkg::*;

    localparam int SP_W   = (STRIP_ID_BITS + 1 > MINW_W) ? STRIP_ID_BITS + 1 : MINW_W;
    localparam int PK_W   = (ADC_BITS > SEED_W) ? ADC_BITS : SEED_W;
    localparam int G_W    = (STRIP_ID_BITS > GAP_W) ? STRIP_ID_BITS : GAP_W;
    localparam int PROD_W = ADC_BITS + STRIP_ID_BITS + 1;

    // Open cluster state.
    logic                     r_open, n_open;
    logic [STRIP_ID_BITS-1:0] r_first, n_first;
    logic [STRIP_ID_BITS-1:0] r_last;
    logic [SUM_W-1:0]         r_sum, n_sum;
    logic [WSUM_W-1:0]        r_wsum, n_wsum;
    logic [ADC_BITS-1:0]      r_peak, n_peak;

    // Second record of a word that closes two clusters.
    logic                     r_hold_v;
    logic [WSUM_W-1:0]        r_hold_wsum;
    logic [SUM_W-1:0]         r_hold_sum;
    logic [ADC_BITS-1:0]      r_hold_peak;
    logic [STRIP_ID_BITS:0]   r_hold_span;

    logic                     accept;
    logic [STRIP_ID_BITS-1:0] id_diff;
    logic                     brk;
    logic                     start;
    logic [STRIP_ID_BITS:0]   old_span;
    logic [STRIP_ID_BITS:0]   new_span;
    logic                     old_pass;
    logic                     new_pass;
    logic                     brk_emit;
    logic                     flush_emit;
    logic [SUM_W-1:0]         base_sum;
    logic [WSUM_W-1:0]        base_wsum;
    logic [ADC_BITS-1:0]      base_peak;
    logic [PROD_W-1:0]        prod;
    logic [SUM_W:0]           sum_ext;
    logic [WSUM_W:0]          wsum_ext;

    assign o_ready = !r_hold_v && !i_full;
    assign accept  = i_valid && o_ready;

    // Break test: descending id or a gap of at least the valley distance.
    assign id_diff = i_strip_id - r_last;
    assign brk     = r_open && ((i_strip_id < r_last) ||
                     (G_W'(id_diff) >= G_W'(i_cfg.valley_gap)));
    assign start   = !r_open || brk;

    // Cuts on the cluster that the break closes.
    assign old_span = {1'b0, r_last} - {1'b0, r_first} + 1'b1;
    assign old_pass = (SP_W'(old_span) >= SP_W'(i_cfg.min_width)) &&
                      (PK_W'(r_peak) > PK_W'(i_cfg.seed_threshold)) &&
                      (r_sum > i_cfg.min_cluster_sum);
    assign brk_emit = brk && old_pass;

    // Add the strip to the open or freshly opened cluster.
    assign base_sum  = start ? '0 : r_sum;
    assign base_wsum = start ? '0 : r_wsum;
    assign base_peak = start ? '0 : r_peak;
    assign n_first   = start ? i_strip_id : r_first;
    assign prod      = PROD_W'(i_amplitude) * PROD_W'({i_strip_id, 1'b1});
    assign sum_ext   = {1'b0, base_sum} + (SUM_W + 1)'(i_amplitude);
    assign wsum_ext  = {1'b0, base_wsum} + (WSUM_W + 1)'(prod);
    assign n_sum     = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
    assign n_wsum    = wsum_ext[WSUM_W] ? WSUM_MAX : wsum_ext[WSUM_W-1:0];
    assign n_peak    = (i_amplitude > base_peak) ? i_amplitude : base_peak;
    assign n_open    = !i_list_end;

    // Cuts on the cluster that the end of the list flushes.
    assign new_span   = {1'b0, i_strip_id} - {1'b0, n_first} + 1'b1;
    assign new_pass   = (SP_W'(new_span) >= SP_W'(i_cfg.min_width)) &&
                        (PK_W'(n_peak) > PK_W'(i_cfg.seed_threshold)) &&
                        (n_sum > i_cfg.min_cluster_sum);
    assign flush_emit = i_list_end && new_pass;

    // Record toward the queue: held record first, then this word's record.
    always_comb begin
        o_push  = 1'b0;
        o_wsum  = n_wsum;
        o_sum   = n_sum;
        o_peak  = n_peak;
        o_span  = new_span;
        o_final = 1'b1;
        if (r_hold_v) begin
            o_push  = 1'b1;
            o_wsum  = r_hold_wsum;
            o_sum   = r_hold_sum;
            o_peak  = r_hold_peak;
            o_span  = r_hold_span;
        end else if (accept && brk_emit) begin
            o_push  = 1'b1;
            o_wsum  = r_wsum;
            o_sum   = r_sum;
            o_peak  = r_peak;
            o_span  = old_span;
            o_final = !flush_emit;
        end else if (accept && flush_emit) begin
            o_push  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open   <= 1'b0;
            r_first  <= '0;
            r_last   <= '0;
            r_sum    <= '0;
            r_wsum   <= '0;
            r_peak   <= '0;
            r_hold_v <= 1'b0;
        end else begin
            if (accept) begin
                r_open  <= n_open;
                r_first <= n_first;
                r_last  <= i_strip_id;
                r_sum   <= n_sum;
                r_wsum  <= n_wsum;
                r_peak  <= n_peak;
            end
            if (r_hold_v) begin
                r_hold_v <= i_full;
            end else if (accept && brk_emit && flush_emit) begin
                r_hold_v <= 1'b1;
            end
        end
    end

    // Flushed cluster parked while the break record goes first.
    always_ff @(posedge i_clk) begin
        if (accept && !r_hold_v) begin
            r_hold_wsum <= n_wsum;
            r_hold_sum  <= n_sum;
            r_hold_peak <= n_peak;
            r_hold_span <= new_span;
        end
    end

endmodule

FILE: hdl/scf_back.sv
// Centroid unit: pops cluster records, divides the weighted sum by twice the
// amplitude sum one quotient bit per cycle and holds the result word. Uses scf_pkg.
module scf_back #(
    parameter int STRIP_ID_BITS = scf_pkg::SCF_ID_BITS,
    parameter int ADC_BITS      = scf_pkg::SCF_ADC_BITS,
    parameter int FRAC_BITS     = scf_pkg::SCF_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_empty,
    output logic                               o_pop,
    input  logic [scf_pkg::WSUM_W-1:0]         i_wsum,
    input  logic [scf_pkg::SUM_W-1:0]          i_sum,
    input  logic [ADC_BITS-1:0]                i_peak,
    input  logic [STRIP_ID_BITS:0]             i_span,
    input  logic                               i_final,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [STRIP_ID_BITS+FRAC_BITS-1:0] o_centroid,
    output logic [scf_pkg::SUM_W-1:0]          o_total_amplitude,
    output logic [ADC_BITS-1:0]                o_peak_amplitude,
    output logic [STRIP_ID_BITS:0]             o_span,
    output logic                               o_final_of_item
);
    import scf_pkg::*;

    localparam int NUM_W  = WSUM_W + FRAC_BITS + 1;
    localparam int DEN_W  = SUM_W + 1;
    localparam int REM_W  = DEN_W + 1;
    localparam int CENT_W = STRIP_ID_BITS + FRAC_BITS;
    localparam int CNT_W  = $clog2(NUM_W + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_cnt;
    logic [NUM_W-1:0]       r_quo;
    logic [DEN_W-1:0]       r_rem;
    logic [DEN_W-1:0]       r_den;
    logic [SUM_W-1:0]       r_sum;
    logic [ADC_BITS-1:0]    r_peak;
    logic [STRIP_ID_BITS:0] r_span;
    logic                   r_final;
    logic                   r_ovalid;
    logic [CENT_W-1:0]      r_out_cent;
    logic [SUM_W-1:0]       r_out_sum;
    logic [ADC_BITS-1:0]    r_out_peak;
    logic [STRIP_ID_BITS:0] r_out_span;
    logic                   r_out_final;

    logic                   out_free;
    logic                   load_out;
    logic [REM_W-1:0]       trial;
    logic                   ge;
    logic [REM_W-1:0]       diff;
    logic [CENT_W-1:0]      cent;

    assign out_free = !r_ovalid || i_ready;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign load_out = (r_state == S_DONE) && out_free;

    // One restoring step: bring down the next numerator bit and try the subtract.
    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign ge    = trial >= REM_W'(r_den);
    assign diff  = trial - REM_W'(r_den);

    // Clamp the quotient to the centroid range.
    assign cent = (|r_quo[NUM_W-1:CENT_W]) ? {CENT_W{1'b1}} : r_quo[CENT_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (!i_empty) n_state = S_DIV;
            S_DIV:  if (r_cnt == CNT_W'(1)) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_cnt <= CNT_W'(NUM_W);
            end else if (r_state == S_DIV) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Divider datapath; the quotient shifts in where the numerator shifts out.
    // The numerator is W*2^F + S, which rounds the quotient half up.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_quo   <= {1'b0, i_wsum, {FRAC_BITS{1'b0}}} + NUM_W'(i_sum);
            r_rem   <= '0;
            r_den   <= {i_sum, 1'b0};
            r_sum   <= i_sum;
            r_peak  <= i_peak;
            r_span  <= i_span;
            r_final <= i_final;
        end else if (r_state == S_DIV) begin
            r_quo <= {r_quo[NUM_W-2:0], ge};
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_cent  <= cent;
            r_out_sum   <= r_sum;
            r_out_peak  <= r_peak;
            r_out_span  <= r_span;
            r_out_final <= r_final;
        end
    end

    assign o_valid           = r_ovalid;
    assign o_centroid        = r_out_cent;
    assign o_total_amplitude = r_out_sum;
    assign o_peak_amplitude  = r_out_peak;
    assign o_span            = r_out_span;
    assign o_final_of_item   = r_out_final;

endmodule

FILE: hdl/strip_cluster_finder_1d.sv
// One-dimensional strip cluster finder: top level with configuration registers.
// Instantiates scf_front, scf_fifo and scf_back; uses scf_pkg.
//
// Strip words (id, amplitude, list end) are taken one per clock by the cluster
// builder as long as its record queue has room; a word that closes one cluster
// and flushes another holds the input until its second record is in the queue.
// Each emitted cluster then goes through the shared bit-serial divider, which
// takes one record at a time and pops the next only once the result word is
// loaded into the output register. The divider limits the sustained output rate;
// the four-entry queue absorbs bursts of clusters in between.
// Configuration writes are always accepted and take effect at once.
module strip_cluster_finder_1d #(
    parameter int STRIP_ID_BITS = scf_pkg::SCF_ID_BITS,
    parameter int ADC_BITS      = scf_pkg::SCF_ADC_BITS,
    parameter int FRAC_BITS     = scf_pkg::SCF_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [scf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [scf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [STRIP_ID_BITS-1:0]           i_strip_id,
    input  logic [ADC_BITS-1:0]                i_amplitude,
    input  logic                               i_list_end,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [STRIP_ID_BITS+FRAC_BITS-1:0] o_centroid,
    output logic [scf_pkg::SUM_W-1:0]          o_total_amplitude,
    output logic [ADC_BITS-1:0]                o_peak_amplitude,
    output logic [STRIP_ID_BITS:0]             o_span,
    output logic                               o_final_of_item
);
    import scf_pkg::*;

    localparam int REC_W = WSUM_W + SUM_W + ADC_BITS + (STRIP_ID_BITS + 1) + 1;

    t_cfg                   r_cfg;

    logic                   f_push;
    logic                   q_full;
    logic                   q_empty;
    logic                   b_pop;
    logic [WSUM_W-1:0]      f_wsum;
    logic [SUM_W-1:0]       f_sum;
    logic [ADC_BITS-1:0]    f_peak;
    logic [STRIP_ID_BITS:0] f_span;
    logic                   f_final;
    logic [REC_W-1:0]       q_in;
    logic [REC_W-1:0]       q_out;
    logic [WSUM_W-1:0]      q_wsum;
    logic [SUM_W-1:0]       q_sum;
    logic [ADC_BITS-1:0]    q_peak;
    logic [STRIP_ID_BITS:0] q_span;
    logic                   q_final;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.valley_gap      <= GAP_W'(3);
            r_cfg.min_width       <= MINW_W'(3);
            r_cfg.seed_threshold  <= '0;
            r_cfg.min_cluster_sum <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_VALLEY_GAP:      r_cfg.valley_gap      <= i_cfg_data[GAP_W-1:0];
                CFG_MIN_WIDTH:       r_cfg.min_width       <= i_cfg_data[MINW_W-1:0];
                CFG_SEED_THRESHOLD:  r_cfg.seed_threshold  <= i_cfg_data[SEED_W-1:0];
                CFG_MIN_CLUSTER_SUM: r_cfg.min_cluster_sum <= i_cfg_data[MINS_W-1:0];
                default: ;
            endcase
        end
    end

    scf_front #(
        .STRIP_ID_BITS (STRIP_ID_BITS),
        .ADC_BITS      (ADC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_strip_id  (i_strip_id),
        .i_amplitude (i_amplitude),
        .i_list_end  (i_list_end),
        .o_push      (f_push),
        .i_full      (q_full),
        .o_wsum      (f_wsum),
        .o_sum       (f_sum),
        .o_peak      (f_peak),
        .o_span      (f_span),
        .o_final     (f_final)
    );

    // Cluster records travel packed through the queue.
    assign q_in = {f_wsum, f_sum, f_peak, f_span, f_final};
    assign {q_wsum, q_sum, q_peak, q_span, q_final} = q_out;

    scf_fifo #(
        .WIDTH (REC_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    scf_back #(
        .STRIP_ID_BITS (STRIP_ID_BITS),
        .ADC_BITS      (ADC_BITS),
        .FRAC_BITS     (FRAC_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (q_empty),
        .o_pop             (b_pop),
        .i_wsum            (q_wsum),
        .i_sum             (q_sum),
        .i_peak            (q_peak),
        .i_span            (q_span),
        .i_final           (q_final),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_centroid        (o_centroid),
        .o_total_amplitude (o_total_amplitude),
        .o_peak_amplitude  (o_peak_amplitude),
        .o_span            (o_span),
        .o_final_of_item   (o_final_of_item)
    );

endmodule
